// ===== rtl/elevator_majority_vote_scheduler_unit_defines.svh =====
`ifndef ELEVATOR_MAJORITY_VOTE_SCHEDULER_UNIT_DEFINES_SVH
`define ELEVATOR_MAJORITY_VOTE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EMVS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EMVS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/emvs_pkg.sv =====
`timescale 1ns / 1ps

package emvs_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;

	localparam int IN_W    = 16;
	localparam int OUT_W   = 56;
	localparam int ENTRY_W = 17;

	localparam logic [7:0]  START_FLOOR_RESET  = 8'd0;
	localparam logic [3:0]  CAR_CAPACITY_RESET = 4'd4;
	localparam logic [7:0]  FLOOR_MAX          = 8'hFF;
	localparam logic [7:0]  FLOOR_MIN          = 8'h00;
	localparam logic [31:0] TICK_MAX           = 32'hFFFF_FFFF;

	localparam logic CFG_START_FLOOR  = 1'b0;
	localparam logic CFG_CAR_CAPACITY = 1'b1;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_UNLOAD,
		ST_BOARD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic ready;
		logic take;
		logic tick_start;
		logic find_hit;
		logic finish;
		logic ev_unload;
		logic ev_board;
	} ctl_t;

endpackage

// ===== rtl/emvs_ram.sv =====
`timescale 1ns / 1ps

module emvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/emvs_ctrl.sv =====
`timescale 1ns / 1ps

module emvs_ctrl #(
	parameter int TABLE_ENTRIES = emvs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_kind,
	input  logic                             slot_free,
	input  logic                             out_free,
	output emvs_pkg::ctl_t                   ctl,
	output logic [$clog2(TABLE_ENTRIES)-1:0] addr,
	output logic [$clog2(TABLE_ENTRIES)-1:0] idx_s1
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	emvs_pkg::state_t state_q;
	emvs_pkg::state_t state_d;
	logic [CW-1:0]    cnt_q;
	logic             live_s1;
	logic             board_s1;
	logic             last_cnt;
	logic             last_slot;

	assign last_cnt  = (cnt_q == CW'(TABLE_ENTRIES));
	assign last_slot = (cnt_q == CW'(TABLE_ENTRIES - 1));
	assign addr      = cnt_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			emvs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_kind == emvs_pkg::KIND_TICK) ?
						emvs_pkg::ST_UNLOAD : emvs_pkg::ST_FIND;
				end
			end
			emvs_pkg::ST_FIND: begin
				if (slot_free || last_slot) begin
					state_d = emvs_pkg::ST_IDLE;
				end
			end
			emvs_pkg::ST_UNLOAD: begin
				if (last_cnt) begin
					state_d = emvs_pkg::ST_BOARD;
				end
			end
			emvs_pkg::ST_BOARD: begin
				if (last_cnt) begin
					state_d = emvs_pkg::ST_FINISH;
				end
			end
			emvs_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = emvs_pkg::ST_IDLE;
				end
			end
			default: state_d = emvs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.ready      = (state_q == emvs_pkg::ST_IDLE);
		ctl.take       = ctl.ready && in_valid;
		ctl.tick_start = ctl.take && (in_kind == emvs_pkg::KIND_TICK);
		ctl.find_hit   = (state_q == emvs_pkg::ST_FIND) && slot_free;
		ctl.finish     = (state_q == emvs_pkg::ST_FINISH) && out_free;
		ctl.ev_unload  = live_s1 && !board_s1;
		ctl.ev_board   = live_s1 && board_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= emvs_pkg::ST_IDLE;
			cnt_q    <= '0;
			live_s1  <= 1'b0;
			board_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == emvs_pkg::ST_FIND || state_q == emvs_pkg::ST_UNLOAD ||
				state_q == emvs_pkg::ST_BOARD) begin
				cnt_q <= cnt_q + CW'(1);
			end
			live_s1  <= (state_q == emvs_pkg::ST_UNLOAD || state_q == emvs_pkg::ST_BOARD) &&
				!last_cnt;
			board_s1 <= (state_q == emvs_pkg::ST_BOARD);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
	end

endmodule

// ===== rtl/emvs_eval.sv =====
`timescale 1ns / 1ps

module emvs_eval #(
	parameter int TABLE_ENTRIES = emvs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  emvs_pkg::ctl_t                     ctl,
	input  logic                               entry_valid,
	input  logic [7:0]                         entry_pickup,
	input  logic [7:0]                         entry_destination,
	input  logic                               entry_aboard,
	input  logic [7:0]                         car_floor,
	input  logic [3:0]                         car_capacity,
	output logic                               clear_valid,
	output logic                               board_wr,
	output logic [3:0]                         riders,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] used,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] up_votes,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] down_votes
);

	localparam int UW = $clog2(TABLE_ENTRIES + 1);

	logic [3:0]    riders_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] up_q;
	logic [UW-1:0] down_q;
	logic          rider;
	logic          dest_hit;
	logic          eff_aboard;
	logic [7:0]    target;

	assign rider       = entry_valid && entry_aboard;
	assign dest_hit    = (entry_destination == car_floor);
	assign clear_valid = ctl.ev_unload && rider && dest_hit;
	assign board_wr    = ctl.ev_board && entry_valid && !entry_aboard &&
		(entry_pickup == car_floor) && (riders_q < car_capacity);
	assign eff_aboard  = entry_aboard || board_wr;
	assign target      = eff_aboard ? entry_destination : entry_pickup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			riders_q <= '0;
			used_q   <= '0;
			up_q     <= '0;
			down_q   <= '0;
		end else if (ctl.tick_start) begin
			riders_q <= '0;
			used_q   <= '0;
			up_q     <= '0;
			down_q   <= '0;
		end else if (ctl.ev_unload) begin
			if (rider && !dest_hit) begin
				riders_q <= riders_q + 4'd1;
			end
		end else if (ctl.ev_board && entry_valid) begin
			used_q <= used_q + UW'(1);
			if (board_wr) begin
				riders_q <= riders_q + 4'd1;
			end
			if (target > car_floor) begin
				up_q <= up_q + UW'(1);
			end else if (target < car_floor) begin
				down_q <= down_q + UW'(1);
			end
		end
	end

	assign riders     = riders_q;
	assign used       = used_q;
	assign up_votes   = up_q;
	assign down_votes = down_q;

endmodule

// ===== rtl/elevator_majority_vote_scheduler_unit.sv =====
// Single-car elevator scheduler. A transfer on the s_ side carries a request (s_tuser low:
// pickup and destination floor) or a tick (s_tuser high). A request scans the valid bits one
// entry a cycle for the lowest free entry and is dropped when the table is full. A tick has two
// sweeps over the whole table and then waits until the output register can take its result:
// one sweep over the passenger RAM unloads and counts riders, a second sweep boards, counts
// entries and votes on the direction, both through one shared compare-and-count unit at one
// entry a cycle. Each tick gives one transfer on the m_ side; a result may wait there while
// the next item is taken. Write start_floor (index 0, also moves the car) and car_capacity
// (index 1) only while the block is idle.
`timescale 1ns / 1ps

`include "elevator_majority_vote_scheduler_unit_defines.svh"

module elevator_majority_vote_scheduler_unit #(
	parameter int TABLE_ENTRIES = emvs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [emvs_pkg::IN_W-1:0]  s_tdata,   // pickup_floor, destination_floor
	input  logic                       s_tuser,   // kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [emvs_pkg::OUT_W-1:0] m_tdata,   // elapsed_ticks, shown_floor, riders,
	                                              // occupied_entries, all_done, zero pad
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int SW = (UW > 8) ? UW : 8;

	emvs_pkg::ctl_t ctl;

	logic [AW-1:0]                addr;
	logic [AW-1:0]                idx_s1;
	logic [TABLE_ENTRIES-1:0]     valid_q;
	logic [7:0]                   floor_q;
	logic [3:0]                   cap_q;
	logic [31:0]                  tick_q;
	logic [31:0]                  tick_next;
	logic [7:0]                   pick_q;
	logic [7:0]                   dest_q;
	logic                         m_tvalid_q;
	logic [31:0]                  elapsed_q;
	logic [7:0]                   shown_q;
	logic [3:0]                   riders_out_q;
	logic [7:0]                   occ_q;
	logic                         done_q;
	logic                         slot_free;
	logic                         out_free;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [emvs_pkg::ENTRY_W-1:0] ram_wdata;
	logic [emvs_pkg::ENTRY_W-1:0] ram_rdata;
	logic                         clear_valid;
	logic                         board_wr;
	logic [3:0]                   riders;
	logic [UW-1:0]                used;
	logic [UW-1:0]                up_votes;
	logic [UW-1:0]                down_votes;
	logic [SW-1:0]                used_ext;
	logic [7:0]                   occ;

	assign slot_free = !valid_q[addr];
	assign out_free  = !m_tvalid_q || m_tready;

	emvs_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.slot_free(slot_free),
		.out_free (out_free),
		.ctl      (ctl),
		.addr     (addr),
		.idx_s1   (idx_s1)
	);

	assign ram_we    = ctl.find_hit || board_wr;
	assign ram_waddr = ctl.find_hit ? addr : idx_s1;
	assign ram_wdata = ctl.find_hit ? {1'b0, dest_q, pick_q} : {1'b1, ram_rdata[15:0]};

	emvs_ram #(
		.WIDTH(emvs_pkg::ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	emvs_eval #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_eval (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.entry_valid      (valid_q[idx_s1]),
		.entry_pickup     (ram_rdata[7:0]),
		.entry_destination(ram_rdata[15:8]),
		.entry_aboard     (ram_rdata[16]),
		.car_floor        (floor_q),
		.car_capacity     (cap_q),
		.clear_valid      (clear_valid),
		.board_wr         (board_wr),
		.riders           (riders),
		.used             (used),
		.up_votes         (up_votes),
		.down_votes       (down_votes)
	);

	assign tick_next = (tick_q == emvs_pkg::TICK_MAX) ? tick_q : tick_q + 32'd1;
	assign used_ext  = SW'(used);
	assign occ       = (used_ext > SW'(255)) ? 8'hFF : used_ext[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.find_hit) begin
			valid_q[addr] <= 1'b1;
		end else if (clear_valid) begin
			valid_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= emvs_pkg::START_FLOOR_RESET;
			cap_q   <= emvs_pkg::CAR_CAPACITY_RESET;
			tick_q  <= '0;
		end else begin
			if (cfg_wr_en && cfg_index == emvs_pkg::CFG_START_FLOOR) begin
				floor_q <= cfg_data;
			end else if (ctl.finish) begin
				tick_q <= tick_next;
				if (up_votes >= down_votes) begin
					if (floor_q != emvs_pkg::FLOOR_MAX) begin
						floor_q <= floor_q + 8'd1;
					end
				end else if (floor_q != emvs_pkg::FLOOR_MIN) begin
					floor_q <= floor_q - 8'd1;
				end
			end
			if (cfg_wr_en && cfg_index == emvs_pkg::CFG_CAR_CAPACITY) begin
				cap_q <= cfg_data[3:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			pick_q <= s_tdata[7:0];
			dest_q <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			elapsed_q    <= tick_next;
			shown_q      <= floor_q;
			riders_out_q <= riders;
			occ_q        <= occ;
			done_q       <= (used == '0);
		end
	end

	assign s_tready = ctl.ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, done_q, occ_q, riders_out_q, shown_q, elapsed_q};

	`EMVS_ASSERT_IMP(a_finish_out_free, ctl.finish, !m_tvalid || m_tready,
		"result produced while output register still full")
	`EMVS_ASSERT_NXT(a_find_sets_valid, ctl.find_hit, valid_q[$past(addr)],
		"stored request entry not marked valid")
	`EMVS_ASSERT_IMP(a_done_matches_occ, m_tvalid, m_tdata[52] == (m_tdata[51:44] == 8'd0),
		"all_done disagrees with occupied_entries")
	`EMVS_ASSERT_IMP(a_idle_no_sweep, s_tready, !ctl.ev_unload && !ctl.ev_board,
		"table sweep active while accepting input")

endmodule
